### rtl/tld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and byte codes of the terminal line discipline block.
// ----------------------------------------------------------------------------
package tld_pkg;

  // Operation codes of one input word
  typedef enum logic [1:0] {
    OP_TERM_IN  = 2'd0,
    OP_PROG_RD  = 2'd1,
    OP_OUT_RD   = 2'd2,
    OP_PROG_OUT = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CANON = 2'd0,
    CFG_ECHO  = 2'd1,
    CFG_CRLF  = 2'd2
  } cfg_idx_e;

  // Byte codes used by line editing
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_DEL   = 8'h7F;
  localparam logic [7:0] CHR_KILL  = 8'h15;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // Largest number of bytes one read returns
  localparam logic [6:0] MAX_RUN = 7'd64;

endpackage : tld_pkg
`default_nettype wire

### rtl/tld_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_in_if
// Request channel: operation, byte and read limit with valid/ready.
// ----------------------------------------------------------------------------
interface tld_in_if;
  logic            valid;
  logic            ready;
  tld_pkg::op_e    op;
  logic [7:0]      in_byte;
  logic [6:0]      max_bytes;

  modport source (output valid, output op, output in_byte, output max_bytes, input ready);
  modport sink   (input valid, input op, input in_byte, input max_bytes, output ready);
endinterface : tld_in_if
`default_nettype wire

### rtl/tld_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_out_if
// Result channel: returned byte, its valid flag and end-of-run mark.
// ----------------------------------------------------------------------------
interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last_of_run;

  modport source (output valid, output data_byte, output data_valid, output last_of_run,
                  input ready);
  modport sink   (input valid, input data_byte, input data_valid, input last_of_run,
                  output ready);
endinterface : tld_out_if
`default_nettype wire

### rtl/tld_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_cfg_if
// Configuration write channel: register index and one data bit.
// ----------------------------------------------------------------------------
interface tld_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : tld_cfg_if
`default_nettype wire

### rtl/tld_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tld_ram
`default_nettype wire

### rtl/tty_line_discipline_with_rings_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tty_line_discipline_with_rings_unit
// One terminal channel: canonical line editing, raw input ring, output ring.
// ----------------------------------------------------------------------------
// A terminal byte in or a program byte out updates the line, the raw ring and
// the output ring in the accept cycle and delivers its single empty result
// word from S_EMPTY (the LF goes in from S_PUT2 first when a CR is inserted
// before it, since the output ring memory has one write port). A read issues
// its first memory read in S_RD_ISSUE after accept, returns the first byte
// from S_RD_DATA and then one byte per cycle while the sink takes them, paced
// by the single read port of the line, raw ring or output ring memory. A new
// request is taken as soon as the previous one has loaded its last word into
// the output register. The memories need no clearing pass after reset.
// ----------------------------------------------------------------------------
module tty_line_discipline_with_rings_unit #(
  parameter int RING_DEPTH = 512,
  parameter int LINE_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tld_cfg_if.sink   cfg_i,
  tld_in_if.sink    in_i,
  tld_out_if.source out_o
);

  localparam int PW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int LW   = $clog2(LINE_DEPTH);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam logic [PW-1:0] PTR_LAST  = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] RING_FULL = CW'(RING_DEPTH);
  localparam logic [LW-1:0] LINE_MAX  = LW'(LINE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_PUT2     = 5'b00010,
    S_EMPTY    = 5'b00100,
    S_RD_ISSUE = 5'b01000,
    S_RD_DATA  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    SRC_LINE = 2'd0,
    SRC_RAW  = 2'd1,
    SRC_OUT  = 2'd2
  } src_e;

  // Configuration
  logic canon_q, echo_q, crlf_q;

  // Ring and line control state
  logic [PW-1:0] raw_head_q, raw_head_d, raw_tail_q, raw_tail_d;
  logic [CW-1:0] raw_cnt_q, raw_cnt_d;
  logic [PW-1:0] out_head_q, out_head_d, out_tail_q, out_tail_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic [LW-1:0] line_len_q, line_len_d;
  logic          line_rdy_q, line_rdy_d;

  // Sequencer
  state_e        state_q, state_d;
  src_e          src_q, src_d;
  logic [6:0]    rem_q, rem_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;

  // Output register
  logic       oval_q, oval_d;
  logic [7:0] obyte_q, obyte_d;
  logic       odv_q, odv_d;
  logic       olast_q, olast_d;

  // Datapath
  logic          in_acc, out_free, rd_issue;
  logic [6:0]    lim, line_need, raw_n, out_n;
  logic [CMPW-1:0] lim_x;
  logic [7:0]    tb, rd_byte;
  logic          raw_put, out_put, line_we;
  logic [7:0]    raw_wbyte, out_wbyte, line_wbyte;
  logic [7:0]    raw_rdata, out_rdata, line_rdata;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !oval_q || out_o.ready;

  // Saturate the read limit and translate CR in canonical mode
  assign lim       = (in_i.max_bytes > tld_pkg::MAX_RUN) ? tld_pkg::MAX_RUN : in_i.max_bytes;
  assign lim_x     = CMPW'(lim);
  assign tb        = (canon_q && in_i.in_byte == tld_pkg::CHR_CR) ? tld_pkg::CHR_LF
                                                                   : in_i.in_byte;
  assign line_need = 7'(line_len_q) + 7'd1;
  assign raw_n     = (CMPW'(raw_cnt_q) < lim_x) ? 7'(raw_cnt_q) : lim;
  assign out_n     = (CMPW'(out_cnt_q) < lim_x) ? 7'(out_cnt_q) : lim;

  // Select the byte of the memory being streamed
  always_comb begin
    case (src_q)
      SRC_LINE: rd_byte = line_rdata;
      SRC_RAW:  rd_byte = raw_rdata;
      default:  rd_byte = out_rdata;
    endcase
  end

  // Sequencer and read-modify-write of the ring and line state
  always_comb begin
    state_d    = state_q;
    src_d      = src_q;
    rem_d      = rem_q;
    rd_idx_d   = rd_idx_q;
    line_len_d = line_len_q;
    line_rdy_d = line_rdy_q;
    raw_head_d = raw_head_q;
    raw_tail_d = raw_tail_q;
    raw_cnt_d  = raw_cnt_q;
    out_head_d = out_head_q;
    out_tail_d = out_tail_q;
    out_cnt_d  = out_cnt_q;
    oval_d     = oval_q && !out_o.ready;
    obyte_d    = obyte_q;
    odv_d      = odv_q;
    olast_d    = olast_q;
    rd_issue   = 1'b0;
    raw_put    = 1'b0;
    raw_wbyte  = in_i.in_byte;
    out_put    = 1'b0;
    out_wbyte  = in_i.in_byte;
    line_we    = 1'b0;
    line_wbyte = tb;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.op)
            tld_pkg::OP_TERM_IN: begin
              state_d = S_EMPTY;
              if (canon_q) begin
                case (tb) inside
                  tld_pkg::CHR_LF: begin
                    line_we    = (line_len_q < LINE_MAX);
                    line_rdy_d = 1'b1;
                  end
                  tld_pkg::CHR_BS, tld_pkg::CHR_DEL: begin
                    if (line_len_q != '0) begin
                      line_len_d = line_len_q - LW'(1);
                    end
                  end
                  tld_pkg::CHR_KILL: begin
                    line_len_d = '0;
                  end
                  default: begin
                    line_we = (line_len_q < LINE_MAX) &&
                              ((tb >= tld_pkg::CHR_SPACE) || (tb == tld_pkg::CHR_TAB));
                  end
                endcase
                if (line_we) begin
                  line_len_d = line_len_q + LW'(1);
                end
              end else begin
                raw_put = 1'b1;
              end
              out_put   = echo_q;
              out_wbyte = tb;
            end
            tld_pkg::OP_PROG_OUT: begin
              out_put = 1'b1;
              if (crlf_q && in_i.in_byte == tld_pkg::CHR_LF) begin
                out_wbyte = tld_pkg::CHR_CR;
                state_d   = S_PUT2;
              end else begin
                state_d = S_EMPTY;
              end
            end
            tld_pkg::OP_PROG_RD: begin
              state_d = S_EMPTY;
              if (lim != '0) begin
                if (canon_q) begin
                  if (line_rdy_q && line_need <= lim) begin
                    line_len_d = '0;
                    line_rdy_d = 1'b0;
                    rd_idx_d   = '0;
                    src_d      = SRC_LINE;
                    rem_d      = 7'(line_len_q);
                    if (line_len_q != '0) begin
                      state_d = S_RD_ISSUE;
                    end
                  end
                end else begin
                  src_d = SRC_RAW;
                  rem_d = raw_n;
                  if (raw_n != '0) begin
                    state_d = S_RD_ISSUE;
                  end
                end
              end
            end
            tld_pkg::OP_OUT_RD: begin
              src_d   = SRC_OUT;
              rem_d   = out_n;
              state_d = (out_n != '0) ? S_RD_ISSUE : S_EMPTY;
            end
          endcase
        end
      end
      S_PUT2: begin
        out_put   = 1'b1;
        out_wbyte = tld_pkg::CHR_LF;
        state_d   = S_EMPTY;
      end
      S_EMPTY: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = '0;
          odv_d   = 1'b0;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        rd_issue = 1'b1;
        state_d  = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = rd_byte;
          odv_d   = 1'b1;
          olast_d = (rem_q == '0);
          if (rem_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_issue = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Advance the read side of the streamed store
    if (rd_issue) begin
      rem_d = rem_q - 7'd1;
      case (src_q)
        SRC_LINE: rd_idx_d = rd_idx_q + LW'(1);
        SRC_RAW: begin
          raw_tail_d = (raw_tail_q == PTR_LAST) ? '0 : raw_tail_q + PW'(1);
          raw_cnt_d  = raw_cnt_q - CW'(1);
        end
        default: begin
          out_tail_d = (out_tail_q == PTR_LAST) ? '0 : out_tail_q + PW'(1);
          out_cnt_d  = out_cnt_q - CW'(1);
        end
      endcase
    end

    // Drop ring writes when the ring is full
    raw_put = raw_put && (raw_cnt_q < RING_FULL);
    out_put = out_put && (out_cnt_q < RING_FULL);
    if (raw_put) begin
      raw_head_d = (raw_head_q == PTR_LAST) ? '0 : raw_head_q + PW'(1);
      raw_cnt_d  = raw_cnt_q + CW'(1);
    end
    if (out_put) begin
      out_head_d = (out_head_q == PTR_LAST) ? '0 : out_head_q + PW'(1);
      out_cnt_d  = out_cnt_q + CW'(1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q <= 1'b0;
      echo_q  <= 1'b0;
      crlf_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        tld_pkg::CFG_CANON: canon_q <= cfg_i.data;
        tld_pkg::CFG_ECHO:  echo_q  <= cfg_i.data;
        tld_pkg::CFG_CRLF:  crlf_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      src_q      <= SRC_LINE;
      rem_q      <= '0;
      rd_idx_q   <= '0;
      line_len_q <= '0;
      line_rdy_q <= 1'b0;
      raw_head_q <= '0;
      raw_tail_q <= '0;
      raw_cnt_q  <= '0;
      out_head_q <= '0;
      out_tail_q <= '0;
      out_cnt_q  <= '0;
      oval_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      src_q      <= src_d;
      rem_q      <= rem_d;
      rd_idx_q   <= rd_idx_d;
      line_len_q <= line_len_d;
      line_rdy_q <= line_rdy_d;
      raw_head_q <= raw_head_d;
      raw_tail_q <= raw_tail_d;
      raw_cnt_q  <= raw_cnt_d;
      out_head_q <= out_head_d;
      out_tail_q <= out_tail_d;
      out_cnt_q  <= out_cnt_d;
      oval_q     <= oval_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    odv_q   <= odv_d;
    olast_q <= olast_d;
  end

  assign out_o.valid       = oval_q;
  assign out_o.data_byte   = obyte_q;
  assign out_o.data_valid  = odv_q;
  assign out_o.last_of_run = olast_q;

  // Stores
  tld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_len_q),
    .wdata_i (line_wbyte),
    .re_i    (rd_issue && src_q == SRC_LINE),
    .raddr_i (rd_idx_q),
    .rdata_o (line_rdata)
  );

  tld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (raw_put),
    .waddr_i (raw_head_q),
    .wdata_i (raw_wbyte),
    .re_i    (rd_issue && src_q == SRC_RAW),
    .raddr_i (raw_tail_q),
    .rdata_o (raw_rdata)
  );

  tld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_put),
    .waddr_i (out_head_q),
    .wdata_i (out_wbyte),
    .re_i    (rd_issue && src_q == SRC_OUT),
    .raddr_i (out_tail_q),
    .rdata_o (out_rdata)
  );

  // Checks
  a_raw_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_cnt_q <= RING_FULL) else $error("raw ring count above depth");

  a_out_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= RING_FULL) else $error("output ring count above depth");

  a_raw_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (raw_cnt_q == '0) |-> (raw_head_q == raw_tail_q))
    else $error("raw ring empty with unequal pointers");

  a_out_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_cnt_q == '0) |-> (out_head_q == out_tail_q))
    else $error("output ring empty with unequal pointers");

  a_issue_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_ISSUE) |=> (state_q == S_RD_DATA))
    else $error("read issue not followed by data stage");

endmodule : tty_line_discipline_with_rings_unit
`default_nettype wire

### sim/tty_line_discipline_with_rings_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_line_discipline_with_rings_unit_test
// Self-checking bench for the terminal line discipline. It sends terminal
// bytes, line and raw reads, output-ring reads and program bytes with random
// source gaps and sink stalls. A behavioral copy of the line editor and both
// rings predicts every result word, and the words are checked in order.
// ----------------------------------------------------------------------------
module tty_line_discipline_with_rings_unit_test;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last_of_run;
  } run_word_t;

  // Line editor and ring predictor plus the in-order result check
  class line_disc_board;
    localparam int RING_CAP = 512;
    localparam int LINE_CAP = 64;

    bit          canon_on;
    bit          echo_on;
    bit          crlf_on;
    logic [7:0]  raw_fifo[$];
    logic [7:0]  echo_fifo[$];
    logic [7:0]  line_buf[LINE_CAP];
    int unsigned line_len;
    bit          line_marked;
    run_word_t   due_words[$];
    bit          error_seen;

    function void apply_setting(tld_pkg::cfg_idx_e idx, bit v);
      case (idx)
        tld_pkg::CFG_CANON: canon_on = v;
        tld_pkg::CFG_ECHO:  echo_on  = v;
        tld_pkg::CFG_CRLF:  crlf_on  = v;
        default: ;
      endcase
    endfunction

    // Drop the byte when the ring is full
    function void fifo_put(ref logic [7:0] q[$], input logic [7:0] b);
      if (q.size() < RING_CAP) q.push_back(b);
    endfunction

    // Keep one slot of the line spare
    function void line_append(logic [7:0] b);
      if (line_len < LINE_CAP - 1) begin
        line_buf[line_len] = b;
        line_len++;
      end
    endfunction

    function void edit_line(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (canon_on) begin
        if (c == tld_pkg::CHR_CR) c = tld_pkg::CHR_LF;
        if (c == tld_pkg::CHR_LF) begin
          line_append(c);
          line_marked = 1'b1;
        end else if (c == tld_pkg::CHR_BS || c == tld_pkg::CHR_DEL) begin
          if (line_len > 0) line_len--;
        end else if (c == tld_pkg::CHR_KILL) begin
          line_len = 0;
        end else if (c >= tld_pkg::CHR_SPACE || c == tld_pkg::CHR_TAB) begin
          line_append(c);
        end
      end else begin
        fifo_put(raw_fifo, c);
      end
      // Echo the translated byte even when the line dropped it
      if (echo_on) fifo_put(echo_fifo, c);
    endfunction

    function void queue_byte(logic [7:0] b);
      due_words.push_back({b, 1'b1, 1'b0});
    endfunction

    // Work out the result words of one accepted request
    function void absorb_request(tld_pkg::op_e op, logic [7:0] b, logic [6:0] lim_in);
      int unsigned lim;
      int unsigned n;
      lim = 32'(lim_in);
      if (lim > tld_pkg::MAX_RUN) lim = 32'(tld_pkg::MAX_RUN);
      n = 0;
      case (op)
        tld_pkg::OP_TERM_IN: edit_line(b);
        tld_pkg::OP_PROG_OUT: begin
          if (b == tld_pkg::CHR_LF && crlf_on) fifo_put(echo_fifo, tld_pkg::CHR_CR);
          fifo_put(echo_fifo, b);
        end
        tld_pkg::OP_PROG_RD: begin
          if (lim > 0) begin
            if (canon_on) begin
              if (line_marked && line_len + 1 <= lim) begin
                for (int i = 0; i < line_len; i++) begin
                  queue_byte(line_buf[i]);
                  n++;
                end
                line_len    = 0;
                line_marked = 1'b0;
              end
            end else begin
              while (n < lim && raw_fifo.size() != 0) begin
                queue_byte(raw_fifo.pop_front());
                n++;
              end
            end
          end
        end
        default: begin
          while (n < lim && echo_fifo.size() != 0) begin
            queue_byte(echo_fifo.pop_front());
            n++;
          end
        end
      endcase
      if (n == 0) due_words.push_back({8'h00, 1'b0, 1'b1});
      else due_words[due_words.size() - 1].last_of_run = 1'b1;
    endfunction

    // Compare one accepted word with the oldest one due
    function void match_word(run_word_t got);
      run_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t: word with none due: byte %02h valid %0b last %0b",
                 $time, got.data_byte, got.data_valid, got.last_of_run);
        error_seen = 1'b1;
        return;
      end
      want = due_words.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $display("%0t: data_byte expected %02h, got %02h",
                 $time, want.data_byte, got.data_byte);
        error_seen = 1'b1;
      end
      if (got.data_valid !== want.data_valid) begin
        $display("%0t: data_valid expected %0b, got %0b",
                 $time, want.data_valid, got.data_valid);
        error_seen = 1'b1;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b, got %0b",
                 $time, want.last_of_run, got.last_of_run);
        error_seen = 1'b1;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  tld_cfg_if cfg_if ();
  tld_in_if  req_if ();
  tld_out_if rsp_if ();

  tty_line_discipline_with_rings_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  line_disc_board board;
  bit             src_steady;
  bit             sink_steady;
  int             sink_hold;
  int unsigned    req_total;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly full reads, some short, a few outside the legal range
  function automatic logic [6:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 7'd64;
    if (r < 90) return 7'($urandom_range(1, 64));
    return 7'($urandom_range(0, 127));
  endfunction

  // Check accepted words and stall the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready)
        board.match_word({rsp_if.data_byte, rsp_if.data_valid, rsp_if.last_of_run});
      if (sink_steady) begin
        rsp_if.ready <= 1'b1;
      end else if (sink_hold > 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        sink_hold = pick_gap();
      end
    end
  end

  // Present one request word, hold it until taken, then maybe idle
  task automatic send_request(tld_pkg::op_e op, logic [7:0] b, logic [6:0] lim);
    int gap;
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.in_byte   <= b;
    req_if.max_bytes <= lim;
    do @(posedge clk_i); while (!req_if.ready);
    board.absorb_request(op, b, lim);
    req_total++;
    gap = src_steady ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_setting(tld_pkg::cfg_idx_e idx, bit v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.apply_setting(idx, v);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the source until every due word has come back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(bit canon, bit echo, bit crlf);
    write_setting(tld_pkg::CFG_CANON, canon);
    write_setting(tld_pkg::CFG_ECHO, echo);
    write_setting(tld_pkg::CFG_CRLF, crlf);
  endtask

  // Type one edited line, end it, then usually read it back
  task automatic type_line();
    int         len;
    int         r;
    logic [7:0] c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 20);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 84) begin
        c = 8'($urandom_range(32, 255));
        if (c == tld_pkg::CHR_DEL) c = 8'h7E;
      end else if (r < 89) begin
        c = r[0] ? tld_pkg::CHR_BS : tld_pkg::CHR_DEL;
      end else if (r < 91) begin
        c = tld_pkg::CHR_KILL;
      end else if (r < 94) begin
        c = tld_pkg::CHR_TAB;
      end else begin
        c = 8'($urandom_range(0, 31));
      end
      send_request(tld_pkg::OP_TERM_IN, c, 7'($urandom_range(0, 127)));
    end
    send_request(tld_pkg::OP_TERM_IN,
                 $urandom_range(0, 1) ? tld_pkg::CHR_CR : tld_pkg::CHR_LF,
                 7'($urandom()));
    if ($urandom_range(0, 4) != 0)
      send_request(tld_pkg::OP_PROG_RD, 8'($urandom()), pick_limit());
    if ($urandom_range(0, 4) < 2)
      send_request(tld_pkg::OP_OUT_RD, 8'($urandom()), 7'd64);
  endtask

  task automatic raw_burst();
    repeat ($urandom_range(1, 10))
      send_request(tld_pkg::OP_TERM_IN, 8'($urandom()), 7'($urandom()));
    send_request(tld_pkg::OP_PROG_RD, 8'($urandom()), pick_limit());
  endtask

  task automatic prog_out_burst();
    repeat ($urandom_range(1, 5))
      send_request(tld_pkg::OP_PROG_OUT,
                   ($urandom_range(0, 9) < 3) ? tld_pkg::CHR_LF : 8'($urandom()),
                   7'($urandom()));
    send_request(tld_pkg::OP_OUT_RD, 8'($urandom()), pick_limit());
  endtask

  // One phase under a random setting, drained at the end
  task automatic run_phase(int n_items);
    int unsigned stop_at;
    int          r;
    bit          canon;
    canon = 1'($urandom_range(0, 1));
    set_mode(canon, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    stop_at = req_total + n_items;
    while (req_total < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        send_request(tld_pkg::op_e'($urandom_range(0, 3)), 8'($urandom()), 7'($urandom()));
      else if (r < 25)
        send_request(tld_pkg::OP_OUT_RD, 8'($urandom()), pick_limit());
      else if (r < 42)
        prog_out_burst();
      else if (canon)
        type_line();
      else
        raw_burst();
    end
    settle();
  endtask

  initial begin
    board = new();
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.op        <= tld_pkg::OP_TERM_IN;
    req_if.in_byte   <= 8'h00;
    req_if.max_bytes <= 7'd0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= tld_pkg::CFG_CANON;
    cfg_if.data      <= 1'b0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    req_total   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Line editing: high bytes, tab, dropped control, erase, CR as LF
    set_mode(1'b1, 1'b1, 1'b1);
    send_request(tld_pkg::OP_TERM_IN, 8'h61, 7'd0);
    send_request(tld_pkg::OP_TERM_IN, 8'hFF, 7'd127);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_TAB, 7'd1);
    send_request(tld_pkg::OP_TERM_IN, 8'h01, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_BS, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_DEL, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_CR, 7'd64);
    // Keep editing after the line is ready, erase the stored LF
    send_request(tld_pkg::OP_TERM_IN, 8'h62, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_BS, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_BS, 7'd64);
    // Zero limit, line too long for limit, saturated limit, line gone
    send_request(tld_pkg::OP_PROG_RD, 8'hFF, 7'd0);
    send_request(tld_pkg::OP_PROG_RD, 8'h00, 7'd1);
    send_request(tld_pkg::OP_PROG_RD, 8'hA5, 7'd127);
    send_request(tld_pkg::OP_PROG_RD, 8'h5A, 7'd64);
    // Line kill on an empty and a filled line
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_KILL, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, 8'h78, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_KILL, 7'd64);
    // Program output with CR before LF, then drain the output ring
    send_request(tld_pkg::OP_PROG_OUT, tld_pkg::CHR_LF, 7'd64);
    send_request(tld_pkg::OP_PROG_OUT, 8'h00, 7'd64);
    send_request(tld_pkg::OP_OUT_RD, 8'h00, 7'd127);
    send_request(tld_pkg::OP_OUT_RD, 8'h00, 7'd0);
    send_request(tld_pkg::OP_OUT_RD, 8'h00, 7'd64);
    settle();

    // Raw queue: no CR translation, partial and empty reads
    set_mode(1'b0, 1'b0, 1'b0);
    send_request(tld_pkg::OP_TERM_IN, tld_pkg::CHR_CR, 7'd64);
    send_request(tld_pkg::OP_TERM_IN, 8'h00, 7'd64);
    send_request(tld_pkg::OP_PROG_RD, 8'h00, 7'd1);
    send_request(tld_pkg::OP_PROG_RD, 8'h00, 7'd127);
    send_request(tld_pkg::OP_PROG_RD, 8'h00, 7'd64);
    settle();

    while (req_total < 150) run_phase($urandom_range(20, 60));

    // Overfill the output ring with CR LF pairs, echo into the full ring, then drain
    set_mode(1'b0, 1'b1, 1'b1);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    repeat (260) send_request(tld_pkg::OP_PROG_OUT, tld_pkg::CHR_LF, 7'($urandom()));
    repeat (4) send_request(tld_pkg::OP_TERM_IN, 8'($urandom()), 7'($urandom()));
    repeat (9) send_request(tld_pkg::OP_OUT_RD, 8'($urandom()), 7'd64);
    send_request(tld_pkg::OP_PROG_RD, 8'($urandom()), 7'd64);
    settle();

    run_phase(40);
    repeat (20) @(posedge clk_i);
    if (!board.error_seen)
      $display("[tty_line_discipline_with_rings_unit] OK");
    else
      $display("[tty_line_discipline_with_rings_unit] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("[tty_line_discipline_with_rings_unit] ERROR");
    $finish;
  end

endmodule : tty_line_discipline_with_rings_unit_test

### sim.f
rtl/tld_pkg.sv
rtl/tld_in_if.sv
rtl/tld_out_if.sv
rtl/tld_cfg_if.sv
rtl/tld_ram.sv
rtl/tty_line_discipline_with_rings_unit.sv
sim/tty_line_discipline_with_rings_unit_test.sv
